// File: sv/delimited_row_field_splitter_defines.svh
// Assertion macros used by the checker file of the field splitter.
`ifndef DELIMITED_ROW_FIELD_SPLITTER_DEFINES_SVH
`define DELIMITED_ROW_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DRFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("drfs: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define DRFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("drfs: assertion failed");

`endif

// File: sv/drfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_pkg
// Types and constants of the delimited row field splitter.
// ----------------------------------------------------------------------------
package drfs_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] cfg_idx_t;
    typedef logic [63:0] cfg_data_t;

    localparam int TDATA_W = 32;
    localparam int SEQ_W   = 3;

    typedef logic [TDATA_W-1:0] tdata_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t CFG_DELIM_BYTES = 3'd0;
    localparam cfg_idx_t CFG_DELIM_LEN   = 3'd1;
    localparam cfg_idx_t CFG_EOL_KIND    = 3'd2;
    localparam cfg_idx_t CFG_QUOTE_MODE  = 3'd3;
    localparam cfg_idx_t CFG_QUOTE_CHAR  = 3'd4;
    localparam cfg_idx_t CFG_ESC_EN      = 3'd5;
    localparam cfg_idx_t CFG_ESC_CHAR    = 3'd6;
    localparam cfg_idx_t CFG_COL_COUNT   = 3'd7;

    // Line end kinds.
    localparam logic [1:0] EOL_LF   = 2'd0;
    localparam logic [1:0] EOL_CR   = 2'd1;
    localparam logic [1:0] EOL_CRLF = 2'd2;

    localparam byte_t CHAR_LF = 8'h0A;
    localparam byte_t CHAR_CR = 8'h0D;

    // Row error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_QUOTE    = 3'd1;
    localparam logic [2:0] ERR_BARE     = 3'd2;
    localparam logic [2:0] ERR_TOO_MANY = 3'd3;
    localparam logic [2:0] ERR_TOO_FEW  = 3'd4;

    // One result word, out_byte in the lowest bits.
    typedef struct packed {
        logic [2:0] error_code;
        logic       row_end;
        logic       field_null;
        logic       field_end;
        logic [9:0] column_index;
        logic       byte_valid;
        byte_t      out_byte;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

// File: sv/delimited_row_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_row_field_splitter
// Splits the bytes of one row into unescaped, column-tagged field bytes.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast last_byte
// m_      | out | m_tvalid/m_tready  | m_tdata result fields, m_tlast last
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// The token engine takes one step per cycle and emits at most one result word;
// an escaped line end or delimiter takes one step per byte it expands to.
// A byte finishes in the cycle of its last step, so plain field bytes run at
// one per cycle; when another word waits in the hold register, it goes out
// first and the last step repeats, and a row error on the final byte adds a step.
// Reset is synchronous; there is no clearing pass after reset.
// A stalled result word holds the engine; an idle engine still takes one byte.
module delimited_row_field_splitter #(
    parameter int MAX_DELIM_LEN = 8,
    parameter int MAX_COLUMNS   = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  drfs_pkg::byte_t    s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] out_byte, [8] byte_valid, [18:9] column_index, [19] field_end,
    // [20] field_null, [21] row_end, [24:22] error_code, rest zero
    output drfs_pkg::tdata_t   m_tdata,
    output logic               m_tlast,   // last
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  drfs_pkg::cfg_idx_t cfg_index,
    input  drfs_pkg::cfg_data_t cfg_data
);
    import drfs_pkg::*;

    localparam int WIN  = MAX_DELIM_LEN + 1;
    localparam int FW   = $clog2(WIN + 2);
    localparam int WIW  = $clog2(WIN);
    localparam int PADN = 2 * WIN;
    localparam int PW   = $clog2(PADN);
    localparam int CNTW = $clog2(MAX_COLUMNS + 1);

    // Configuration registers.
    logic [63:0] delim_reg;
    logic [3:0]  dlen_cfg_reg;
    logic [1:0]  eol_reg;
    logic        qm_reg;
    byte_t       quote_reg;
    logic        esc_en_reg;
    byte_t       esc_char_reg;
    logic [10:0] ccount_reg;

    // Row state.
    byte_t            win_reg [WIN];
    logic [FW-1:0]    fill_reg;
    logic [CNTW-1:0]  col_reg;
    logic             fhb_reg;
    logic             row_start_reg;
    logic             eoq_reg;
    logic [2:0]       err_reg;
    logic             lastb_reg;
    logic             busy_reg;
    logic [SEQ_W-1:0] sidx_reg;

    logic hold_valid_reg;
    res_t hold_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic out_last_reg;

    // Derived settings.
    logic [FW-1:0]   dlen, elen, look;
    logic            crlf;
    byte_t           eol0, esc;
    logic            esc_on;
    logic [CNTW-1:0] count;

    always_comb begin
        if (dlen_cfg_reg == 4'd0) begin
            dlen = FW'(1);
        end else if (32'(dlen_cfg_reg) > MAX_DELIM_LEN) begin
            dlen = FW'(MAX_DELIM_LEN);
        end else begin
            dlen = FW'(dlen_cfg_reg);
        end
        crlf   = (eol_reg == EOL_CRLF);
        elen   = crlf ? FW'(2) : FW'(1);
        eol0   = (eol_reg == EOL_CR || crlf) ? CHAR_CR : CHAR_LF;
        look   = FW'(1) + ((dlen > elen) ? dlen : elen);
        esc    = (qm_reg && !esc_en_reg) ? quote_reg : esc_char_reg;
        esc_on = qm_reg || esc_en_reg;
        if (32'(ccount_reg) > MAX_COLUMNS) begin
            count = CNTW'(MAX_COLUMNS);
        end else begin
            count = CNTW'(ccount_reg);
        end
    end

    // Token engine: one token step per cycle while the output register is free.
    byte_t            winx [PADN];
    byte_t            win_s [WIN];
    logic [FW-1:0]    limit, k, fill_e, seq_len;
    logic [CNTW-1:0]  col_e;
    logic             fhb_e, rs_e, eoq_e;
    logic [2:0]       err_e;
    logic [SEQ_W-1:0] sidx_e;
    logic             emit, fin0, early, fin, defer, do_close, do_seq, seq_eol;
    logic             m0, m1, meol, row_clear;
    res_t             res;
    byte_t            w0, w1, w2;
    logic [CNTW:0]    col_p1;
    logic             active, out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign active   = busy_reg && out_free;

    always_comb begin
        for (int j = 0; j < PADN; j++) begin
            winx[j] = (j < WIN) ? win_reg[WIW'(j)] : 8'h00;
        end
        w0 = winx[0];
        w1 = winx[1];
        w2 = winx[2];
        limit  = (qm_reg && lastb_reg) ? fill_reg - FW'(1) : fill_reg;
        col_p1 = {1'b0, col_reg} + (CNTW+1)'(1);

        m0 = (dlen <= limit);
        m1 = ({1'b0, dlen} + (FW+1)'(1) <= {1'b0, limit});
        for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (FW'(i) < dlen && winx[i] != delim_reg[8*i +: 8]) begin
                m0 = 1'b0;
            end
            if (FW'(i) < dlen && winx[i+1] != delim_reg[8*i +: 8]) begin
                m1 = 1'b0;
            end
        end
        meol = ({1'b0, elen} + (FW+1)'(1) <= {1'b0, limit}) && w1 == eol0 &&
               (!crlf || w2 == CHAR_LF);

        fill_e    = fill_reg;
        col_e     = col_reg;
        fhb_e     = fhb_reg;
        rs_e      = row_start_reg;
        eoq_e     = eoq_reg;
        err_e     = err_reg;
        sidx_e    = sidx_reg;
        k         = '0;
        emit      = 1'b0;
        fin0      = 1'b0;
        do_close  = 1'b0;
        do_seq    = 1'b0;
        seq_eol   = 1'b0;
        row_clear = 1'b0;
        res       = '0;
        res.column_index = 10'(col_reg);

        if (err_reg != ERR_NONE) begin
            fin0   = 1'b1;
            fill_e = '0;
            if (lastb_reg) begin
                emit           = 1'b1;
                res.row_end    = 1'b1;
                res.error_code = err_reg;
                row_clear      = 1'b1;
            end
        end else if (!lastb_reg && fill_reg < look) begin
            fin0 = 1'b1;
        end else if (qm_reg && lastb_reg && fill_reg == '0) begin
            err_e = ERR_QUOTE;
        end else if (qm_reg && eoq_reg) begin
            if (limit == '0 || w0 != quote_reg) begin
                err_e = ERR_QUOTE;
            end else begin
                k     = FW'(1);
                eoq_e = 1'b0;
            end
        end else if (limit == '0) begin
            if (qm_reg && w0 != quote_reg) begin
                err_e = ERR_QUOTE;
            end else begin
                emit           = 1'b1;
                res.field_end  = 1'b1;
                res.field_null = !fhb_reg;
                res.row_end    = 1'b1;
                res.error_code = (col_p1 < {1'b0, count}) ? ERR_TOO_FEW : ERR_NONE;
                row_clear      = 1'b1;
                fin0           = 1'b1;
            end
        end else if (qm_reg) begin
            if (esc_on && w0 == esc && limit >= FW'(2) &&
                (w1 == esc || w1 == quote_reg)) begin
                emit           = 1'b1;
                res.byte_valid = 1'b1;
                res.out_byte   = w1;
                fhb_e          = 1'b1;
                k              = FW'(2);
            end else if (w0 == quote_reg && m1) begin
                k        = FW'(1) + dlen;
                do_close = 1'b1;
            end else if (w0 == quote_reg && w0 != esc) begin
                err_e = ERR_BARE;
            end else begin
                emit           = 1'b1;
                res.byte_valid = 1'b1;
                res.out_byte   = w0;
                fhb_e          = 1'b1;
                k              = FW'(1);
            end
        end else begin
            if (m0) begin
                k        = dlen;
                do_close = 1'b1;
            end else if (esc_on && w0 == esc && limit >= FW'(2) && w1 == esc) begin
                emit           = 1'b1;
                res.byte_valid = 1'b1;
                res.out_byte   = esc;
                fhb_e          = 1'b1;
                k              = FW'(2);
            end else if (esc_on && w0 == esc && meol) begin
                do_seq  = 1'b1;
                seq_eol = 1'b1;
            end else if (esc_on && w0 == esc && m1) begin
                do_seq = 1'b1;
            end else begin
                emit           = 1'b1;
                res.byte_valid = 1'b1;
                res.out_byte   = w0;
                fhb_e          = 1'b1;
                k              = FW'(1);
            end
        end

        // An escaped line end or delimiter comes out one byte per cycle while the output is free.
        seq_len = seq_eol ? elen : dlen;
        if (do_seq) begin
            emit           = 1'b1;
            res.byte_valid = 1'b1;
            if (seq_eol) begin
                res.out_byte = (sidx_reg == '0) ? eol0 : CHAR_LF;
            end else begin
                res.out_byte = delim_reg[{sidx_reg, 3'b000} +: 8];
            end
            if (5'(sidx_reg) + 5'd1 == 5'(seq_len)) begin
                k      = FW'(1) + seq_len;
                fhb_e  = 1'b1;
                sidx_e = '0;
            end else begin
                sidx_e = sidx_reg + SEQ_W'(1);
            end
        end

        if (do_close) begin
            emit           = 1'b1;
            res.field_end  = 1'b1;
            res.field_null = !fhb_reg;
            if (col_p1 >= {1'b0, count}) begin
                err_e = ERR_TOO_MANY;
            end else begin
                col_e = CNTW'(col_p1);
                fhb_e = 1'b0;
                if (qm_reg) begin
                    eoq_e = 1'b1;
                end
            end
        end

        if (k != '0) begin
            fill_e = (k >= fill_reg) ? '0 : fill_reg - k;
        end

        if (row_clear) begin
            fill_e = '0;
            col_e  = '0;
            fhb_e  = 1'b0;
            rs_e   = 1'b1;
            eoq_e  = 1'b1;
            err_e  = ERR_NONE;
        end

        // Finish the step in the same cycle when the next check would stop.
        early = !fin0 && sidx_e == '0 && !lastb_reg &&
                (err_e != ERR_NONE || fill_e < look) && !(emit && hold_valid_reg);
        if (early && err_e != ERR_NONE) begin
            fill_e = '0;
        end
        fin   = fin0 || early;
        defer = fin && emit && hold_valid_reg;

        for (int i = 0; i < WIN; i++) begin
            win_s[i] = winx[PW'(i) + PW'(k)];
        end
    end

    logic accept;
    assign s_tready  = !busy_reg || (active && fin && !defer);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Merge of engine commit and byte intake.
    byte_t            win_next [WIN];
    logic [FW-1:0]    fill_next;
    logic [CNTW-1:0]  col_next;
    logic             fhb_next, rs_next, eoq_next, busy_next, lastb_next;
    logic [2:0]       err_next;
    logic [SEQ_W-1:0] sidx_next;
    logic             hold_valid_next, push, push_last;
    res_t             hold_next, push_res;
    logic             commit;

    always_comb begin
        commit = active && !defer;
        for (int i = 0; i < WIN; i++) begin
            win_next[i] = commit ? win_s[i] : win_reg[i];
        end
        fill_next  = commit ? fill_e : fill_reg;
        col_next   = commit ? col_e : col_reg;
        fhb_next   = commit ? fhb_e : fhb_reg;
        rs_next    = commit ? rs_e : row_start_reg;
        eoq_next   = commit ? eoq_e : eoq_reg;
        err_next   = commit ? err_e : err_reg;
        sidx_next  = commit ? sidx_e : sidx_reg;
        busy_next  = (commit && fin) ? 1'b0 : busy_reg;
        lastb_next = lastb_reg;

        if (accept) begin
            busy_next  = 1'b1;
            lastb_next = s_tlast;
            if (rs_next) begin
                rs_next = 1'b0;
                if (ccount_reg == 11'd0) begin
                    err_next = ERR_TOO_MANY;
                end
            end
            if (err_next == ERR_NONE && fill_next < FW'(WIN)) begin
                win_next[fill_next[WIW-1:0]] = s_tdata;
                fill_next = fill_next + FW'(1);
            end
        end

        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        push_res        = hold_reg;
        if (active) begin
            if (defer) begin
                push            = 1'b1;
                hold_valid_next = 1'b0;
            end else if (emit && fin) begin
                push      = 1'b1;
                push_last = 1'b1;
                push_res  = res;
            end else if (emit) begin
                push            = hold_valid_reg;
                hold_next       = res;
                hold_valid_next = 1'b1;
            end else if (fin) begin
                push            = hold_valid_reg;
                push_last       = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg      <= 64'd44;
            dlen_cfg_reg   <= 4'd1;
            eol_reg        <= EOL_LF;
            qm_reg         <= 1'b0;
            quote_reg      <= 8'd34;
            esc_en_reg     <= 1'b0;
            esc_char_reg   <= 8'd34;
            ccount_reg     <= 11'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELIM_BYTES: delim_reg    <= cfg_data;
                CFG_DELIM_LEN:   dlen_cfg_reg <= cfg_data[3:0];
                CFG_EOL_KIND:    eol_reg      <= cfg_data[1:0];
                CFG_QUOTE_MODE:  qm_reg       <= cfg_data[0];
                CFG_QUOTE_CHAR:  quote_reg    <= cfg_data[7:0];
                CFG_ESC_EN:      esc_en_reg   <= cfg_data[0];
                CFG_ESC_CHAR:    esc_char_reg <= cfg_data[7:0];
                CFG_COL_COUNT:   ccount_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            col_reg        <= '0;
            fhb_reg        <= 1'b0;
            row_start_reg  <= 1'b1;
            eoq_reg        <= 1'b1;
            err_reg        <= ERR_NONE;
            lastb_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            sidx_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            col_reg        <= col_next;
            fhb_reg        <= fhb_next;
            row_start_reg  <= rs_next;
            eoq_reg        <= eoq_next;
            err_reg        <= err_next;
            lastb_reg      <= lastb_next;
            busy_reg       <= busy_next;
            sidx_reg       <= sidx_next;
            hold_valid_reg <= hold_valid_next;
            if (out_free) begin
                out_valid_reg <= push;
                out_last_reg  <= push_last;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < WIN; i++) begin
            win_reg[i] <= win_next[i];
        end
        hold_reg <= hold_next;
        if (out_free) begin
            out_reg <= push_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, out_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/drfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_checker
// Port-level checks on the result stream of the field splitter.
// ----------------------------------------------------------------------------
`include "delimited_row_field_splitter_defines.svh"

module drfs_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input drfs_pkg::tdata_t m_tdata,
    input logic             m_tlast
);
    import drfs_pkg::*;

    res_t r;
    assign r = m_tdata[RES_W-1:0];

    // A stalled word holds its payload.
    `DRFS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // Errors are reported only on the close of a row.
    `DRFS_ASSERT_IMP(a_err_row, aclk, aresetn, m_tvalid && r.error_code != ERR_NONE, r.row_end)
    // A null mark only comes with a field close.
    `DRFS_ASSERT_IMP(a_null_end, aclk, aresetn, m_tvalid && r.field_null, r.field_end)
    // Data words never close a field or a row.
    `DRFS_ASSERT_IMP(a_data_word, aclk, aresetn, m_tvalid && r.byte_valid, !r.field_end && !r.row_end)
    // The row close is the final word of its input byte.
    `DRFS_ASSERT_IMP(a_row_last, aclk, aresetn, m_tvalid && r.row_end, m_tlast)

endmodule

bind delimited_row_field_splitter drfs_checker u_drfs_checker (.*);
